>>> rtl/irn_pkg.sv
`default_nettype none

package irn_pkg;

   // ascii codes of the numeral letters
   localparam logic [6:0] LetterI = 7'h49;
   localparam logic [6:0] LetterV = 7'h56;
   localparam logic [6:0] LetterX = 7'h58;
   localparam logic [6:0] LetterL = 7'h4c;
   localparam logic [6:0] LetterC = 7'h43;
   localparam logic [6:0] LetterD = 7'h44;
   localparam logic [6:0] LetterM = 7'h4d;

   // largest value that gets converted
   localparam int ValueLimit = 3999;

   // decimal places, units first
   localparam int NumPlaces = 4;
   localparam logic [1:0] PlaceUnits     = 2'd0;
   localparam logic [1:0] PlaceTens      = 2'd1;
   localparam logic [1:0] PlaceHundreds  = 2'd2;
   localparam logic [1:0] PlaceThousands = 2'd3;

   // queue between front and back
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   typedef logic [3:0] digit_type;
   typedef logic [1:0] place_type;
   typedef logic [1:0] pos_type;

   // one number split into decimal digits, index is the place
   typedef struct packed {
      digit_type [NumPlaces-1:0] digits;
   } entry_type;

   // number of letters that spell one digit
   function automatic logic [2:0] digit_len(input digit_type d);
      logic [2:0] n;
      unique case (d)
         4'd1:    n = 3'd1;
         4'd2:    n = 3'd2;
         4'd3:    n = 3'd3;
         4'd4:    n = 3'd2;
         4'd5:    n = 3'd1;
         4'd6:    n = 3'd2;
         4'd7:    n = 3'd3;
         4'd8:    n = 3'd4;
         4'd9:    n = 3'd2;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // letters of a place
   function automatic logic [6:0] one_letter(input place_type p);
      logic [6:0] c;
      unique case (p)
         PlaceUnits:    c = LetterI;
         PlaceTens:     c = LetterX;
         PlaceHundreds: c = LetterC;
         default:       c = LetterM;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] five_letter(input place_type p);
      logic [6:0] c;
      unique case (p)
         PlaceUnits:    c = LetterV;
         PlaceTens:     c = LetterL;
         default:       c = LetterD;
      endcase
      return c;
   endfunction

   function automatic logic [6:0] ten_letter(input place_type p);
      logic [6:0] c;
      unique case (p)
         PlaceUnits:    c = LetterX;
         PlaceTens:     c = LetterC;
         default:       c = LetterM;
      endcase
      return c;
   endfunction

   // letter at position pos of the spelling of digit d in place p
   function automatic logic [6:0] pick_letter(input place_type p, input digit_type d,
                                              input pos_type pos);
      logic [6:0] c;
      priority if (d == 4'd9) begin
         c = (pos == 2'd0) ? one_letter(p) : ten_letter(p);
      end else if (d == 4'd4) begin
         c = (pos == 2'd0) ? one_letter(p) : five_letter(p);
      end else if (d >= 4'd5) begin
         c = (pos == 2'd0) ? five_letter(p) : one_letter(p);
      end else begin
         c = one_letter(p);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> rtl/irn_front.sv
`default_nettype none

module irn_front import irn_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [11:0] in_value,
   output logic             push,
   output entry_type        push_entry,
   input  wire logic        queue_full
);

   logic            s1_valid_ff, s1_valid_in;
   logic [1:0]      s1_thou_ff, s1_thou_in;
   logic [9:0]      s1_rem_ff, s1_rem_in;
   logic            s2_valid_ff, s2_valid_in;
   logic [1:0]      s2_thou_ff;
   digit_type       s2_hund_ff, s2_hund_in;
   logic [6:0]      s2_rem_ff, s2_rem_in;
   logic            s3_valid_ff, s3_valid_in;
   entry_type       s3_entry_ff, s3_entry_in;
   logic            advance;
   logic            keep;

   // whole pipe moves together, stalls only when the queue is full
   assign advance  = !s3_valid_ff || !queue_full;
   assign in_ready = advance;
   assign push     = s3_valid_ff && !queue_full;
   assign push_entry = s3_entry_ff;

   // zero and out of range values produce no letters and are dropped here
   assign keep = (in_value != 12'd0) && (in_value <= 12'(ValueLimit));

   // thousands
   always_comb begin
      s1_valid_in = in_valid && keep;
      priority if (in_value >= 12'd3000) begin
         s1_thou_in = 2'd3;
         s1_rem_in  = 10'(in_value - 12'd3000);
      end else if (in_value >= 12'd2000) begin
         s1_thou_in = 2'd2;
         s1_rem_in  = 10'(in_value - 12'd2000);
      end else if (in_value >= 12'd1000) begin
         s1_thou_in = 2'd1;
         s1_rem_in  = 10'(in_value - 12'd1000);
      end else begin
         s1_thou_in = 2'd0;
         s1_rem_in  = in_value[9:0];
      end
   end

   // hundreds
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_hund_in  = 4'd0;
      s2_rem_in   = s1_rem_ff[6:0];
      for (int k = 1; k <= 9; k++) begin
         if (s1_rem_ff >= 10'(k * 100)) begin
            s2_hund_in = 4'(k);
            s2_rem_in  = 7'(s1_rem_ff - 10'(k * 100));
         end
      end
   end

   // tens and units
   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_entry_in.digits[PlaceThousands] = {2'b00, s2_thou_ff};
      s3_entry_in.digits[PlaceHundreds]  = s2_hund_ff;
      s3_entry_in.digits[PlaceTens]      = 4'd0;
      s3_entry_in.digits[PlaceUnits]     = s2_rem_ff[3:0];
      for (int k = 1; k <= 9; k++) begin
         if (s2_rem_ff >= 7'(k * 10)) begin
            s3_entry_in.digits[PlaceTens]  = 4'(k);
            s3_entry_in.digits[PlaceUnits] = 4'(s2_rem_ff - 7'(k * 10));
         end
      end
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_thou_ff  <= s1_thou_in;
         s1_rem_ff   <= s1_rem_in;
         s2_thou_ff  <= s1_thou_ff;
         s2_hund_ff  <= s2_hund_in;
         s2_rem_ff   <= s2_rem_in;
         s3_entry_ff <= s3_entry_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/irn_queue.sv
`default_nettype none

module irn_queue import irn_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  entry_type push_entry,
   output logic      full,
   output logic      head_valid,
   output entry_type head_entry,
   input  wire logic pop
);

   entry_type              slot_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !(pop && head_valid)) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop && head_valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop && head_valid) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

>>> rtl/irn_back.sv
`default_nettype none

module irn_back import irn_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  entry_type       head_entry,
   output logic            pop,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [6:0]      out_letter,
   output logic            out_last
);

   logic        busy_ff, busy_in;
   entry_type   work_ff, work_in;
   place_type   place_ff, place_in;
   pos_type     pos_ff, pos_in;
   logic        valid_ff, valid_in;
   logic [6:0]  letter_ff, letter_in;
   logic        last_ff, last_in;

   entry_type   cur_entry;
   place_type   cur_place;
   pos_type     cur_pos;
   digit_type   cur_digit;
   logic [3:0]  nonzero;
   logic [3:0]  lower;
   place_type   top_place;
   place_type   next_place;
   logic        digit_end;
   logic        active;
   logic        advance;

   assign out_valid  = valid_ff;
   assign out_letter = letter_ff;
   assign out_last   = last_ff;

   // output register takes a new letter when empty or being taken
   assign advance = !valid_ff || out_ready;
   assign active  = busy_ff || head_valid;
   assign pop     = advance && !busy_ff && head_valid;

   // a fresh item starts straight from the queue head
   assign cur_entry = busy_ff ? work_ff : head_entry;
   assign cur_pos   = busy_ff ? pos_ff : 2'd0;

   always_comb begin
      for (int i = 0; i < NumPlaces; i++) begin
         nonzero[i] = (cur_entry.digits[i] != 4'd0);
      end
      // highest nonzero place of the head item
      top_place = PlaceUnits;
      for (int i = 1; i < NumPlaces; i++) begin
         if (nonzero[i]) begin
            top_place = place_type'(i);
         end
      end
   end

   assign cur_place = busy_ff ? place_ff : top_place;
   assign cur_digit = cur_entry.digits[cur_place];
   assign digit_end = ({1'b0, cur_pos} + 3'd1) == digit_len(cur_digit);

   // next nonzero place below the current one
   always_comb begin
      lower      = nonzero & ((4'd1 << cur_place) - 4'd1);
      next_place = PlaceUnits;
      for (int i = 1; i < NumPlaces; i++) begin
         if (lower[i]) begin
            next_place = place_type'(i);
         end
      end
   end

   // letter sequencer
   always_comb begin
      busy_in   = busy_ff;
      work_in   = work_ff;
      place_in  = place_ff;
      pos_in    = pos_ff;
      valid_in  = valid_ff && !out_ready;
      letter_in = letter_ff;
      last_in   = last_ff;
      if (advance && active) begin
         valid_in  = 1'b1;
         letter_in = pick_letter(cur_place, cur_digit, cur_pos);
         last_in   = digit_end && (lower == 4'd0);
         work_in   = cur_entry;
         busy_in   = !last_in;
         if (digit_end) begin
            place_in = next_place;
            pos_in   = 2'd0;
         end else begin
            place_in = cur_place;
            pos_in   = cur_pos + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      place_ff  <= place_in;
      pos_ff    <= pos_in;
      letter_ff <= letter_in;
      last_ff   <= last_in;
   end

endmodule

`default_nettype wire

>>> rtl/integer_to_roman_numeral_core.sv
// Converts a number from 0 to 3999 into its Roman numeral, sent out as a run
// of ASCII letters (I V X L C D M), most significant place first, one letter
// per cycle while rsp_tready is high, with rsp_tlast on the final letter.
// A number spells to at most 15 letters (for 3888); the sequencer in the back
// part steps through the letters. Zero and values above 3999 produce no
// letters and are dropped. Numbers pass a three-stage digit split and a
// four-entry queue, so new numbers are taken every cycle until the queue fills.
`default_nettype none

module integer_to_roman_numeral_core import irn_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [11:0] value, [15:12] ignored
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [6:0] letter, [7] zero
   output logic             rsp_tlast
);

   logic       push;
   entry_type  push_entry;
   logic       queue_full;
   logic       head_valid;
   entry_type  head_entry;
   logic       pop;
   logic [6:0] letter;

   irn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_value   (req_tdata[11:0]),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   irn_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   irn_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_letter (letter),
      .out_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, letter};

endmodule

`default_nettype wire
